/* sv/estc_pkg.sv */
// estc_pkg: shared types, constants and the month-length table
// for the epoch-to-calendar converter; no dependencies
`default_nettype none

package estc_pkg;

	// widths of the epoch count, the zone offset, the whole-day count and the year
	localparam int EPOCH_W  = 32;
	localparam int OFFSET_W = 17;
	localparam int DAYS_W   = EPOCH_W - 16;
	localparam int YEAR_W   = 12;

	localparam logic signed [OFFSET_W-1:0] OFFSET_RESET = 17'sd28800;
	localparam logic [YEAR_W-1:0]          BASE_YEAR    = 12'd1970;

	// year residues of the base year for the leap rule
	localparam logic [1:0] BASE_MOD4   = 2'd2;
	localparam logic [6:0] BASE_MOD100 = 7'd70;
	localparam logic [8:0] BASE_MOD400 = 9'd370;

	// reciprocal constants: x/60 = (x*M60)>>37, x/3 = (x*M3)>>33, exact for 32-bit x
	localparam logic [31:0] MAGIC_DIV60 = 32'h8888_8889;
	localparam logic [31:0] MAGIC_DIV3  = 32'hAAAA_AAAB;

	localparam logic [3:0] LAST_MONTH = 4'd11;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_REM,
		ST_YEAR,
		ST_MONTH
	} estc_state_t;

	// which split the shared multiplier is doing
	typedef enum logic [1:0] {
		DV_SEC,
		DV_MIN,
		DV_HR
	} estc_div_t;

	typedef struct packed {
		logic [YEAR_W-1:0] year;
		logic [3:0]        month;
		logic [4:0]        day;
		logic [4:0]        hour;
		logic [5:0]        minute;
		logic [5:0]        second;
	} estc_cal_t;

	function automatic logic [4:0] month_len(input logic leap, input logic [3:0] mon);
		logic [4:0] len;
		case (mon)
			4'd1:                      len = leap ? 5'd29 : 5'd28;
			4'd3, 4'd5, 4'd8, 4'd10:   len = 5'd30;
			default:                   len = 5'd31;
		endcase
		return len;
	endfunction

endpackage

`default_nettype wire

/* sv/estc_if.sv */
// estc_if: valid/ready channel interfaces for the epoch input and the calendar output
// depends on estc_pkg
`default_nettype none

interface estc_epoch_if import estc_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [EPOCH_W-1:0] epoch_seconds;

	modport source (output valid, output epoch_seconds, input ready);
	modport sink   (input valid, input epoch_seconds, output ready);
endinterface

interface estc_cal_if import estc_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [YEAR_W-1:0] year;
	logic [3:0]        month;
	logic [4:0]        day;
	logic [4:0]        hour;
	logic [5:0]        minute;
	logic [5:0]        second;

	modport source (output valid, output year, output month, output day,
		output hour, output minute, output second, input ready);
	modport sink   (input valid, input year, input month, input day,
		input hour, input minute, input second, output ready);
endinterface

`default_nettype wire

/* sv/epoch_seconds_to_calendar_core.sv */
// epoch_seconds_to_calendar_core: unix seconds plus zone offset to gregorian date and time
// depends on estc_pkg and the channel interfaces in estc_if.sv
//
//   channel    dir  handshake      payload
//   epoch_in   in   valid/ready    epoch_seconds[31:0]
//   cal_out    out  valid/ready    year[11:0] month[3:0] day[4:0] hour[4:0] minute[5:0] second[5:0]
//   cfg        in   cfg_we         cfg_wdata[16:0] signed zone offset, no read-back
//
// one item at a time: accept, then the second/minute/hour split on one shared 32x32
// multiplier, each split a quotient step then a remainder step, then a walk over the years
// and the months, one year or one month per step plus a closing step for each walk
// results sit in an output register, so the next beat is taken while one waits
// arst_n clears the sequencer, output valid and loads the offset of utc+8
`default_nettype none

module epoch_seconds_to_calendar_core import estc_pkg::*; (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	estc_epoch_if.sink                      epoch_in,
	estc_cal_if.source                      cal_out,
	input  wire logic                       cfg_we,
	input  wire logic signed [OFFSET_W-1:0] cfg_wdata
);

	estc_state_t state_q, state_d;

	logic signed [OFFSET_W-1:0] offset_q;

	// working registers of the sequencer
	logic [EPOCH_W-1:0] work_q;   // value being split
	logic [EPOCH_W-1:0] quot_q;   // quotient from the multiplier
	estc_div_t          div_q;
	logic [5:0]         sec_q;
	logic [5:0]         min_q;
	logic [4:0]         hr_q;
	logic [DAYS_W-1:0]  days_q;
	logic [YEAR_W-1:0]  year_q;
	logic [1:0]         mod4_q;
	logic [6:0]         mod100_q;
	logic [8:0]         mod400_q;
	logic               leap_q;
	logic [3:0]         mon_q;

	logic      out_valid_q;
	estc_cal_t out_q;

	// control from the sequencer
	logic accept;
	logic load_out;
	logic last_div;
	logic year_done;
	logic month_step;

	// ---------------------------------------------------------------
	// offset register
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q <= OFFSET_RESET;
		end else if (cfg_we) begin
			offset_q <= cfg_wdata;
		end
	end

	// ---------------------------------------------------------------
	// offset add with clamp to the epoch range
	// ---------------------------------------------------------------
	logic signed [EPOCH_W+1:0] sum;
	logic [EPOCH_W-1:0]        clamped;

	assign sum = $signed({2'b00, epoch_in.epoch_seconds})
		+ (EPOCH_W+2)'(offset_q);

	always_comb begin
		if (sum[EPOCH_W+1]) begin
			clamped = '0;                 // below zero
		end else if (sum[EPOCH_W]) begin
			clamped = '1;                 // past the top of the range
		end else begin
			clamped = sum[EPOCH_W-1:0];
		end
	end

	// ---------------------------------------------------------------
	// shared multiplier: divide by 60, by 60, then by 24 as (x>>3)/3
	// ---------------------------------------------------------------
	logic [EPOCH_W-1:0]   mul_a;
	logic [31:0]          mul_b;
	logic [2*EPOCH_W-1:0] prod;
	logic [EPOCH_W-1:0]   quot_d;
	logic [EPOCH_W-1:0]   quot_x_div;
	logic [EPOCH_W-1:0]   rem;

	always_comb begin
		unique case (div_q)
			DV_HR: begin
				mul_a = {3'b000, work_q[EPOCH_W-1:3]};
				mul_b = MAGIC_DIV3;
			end
			default: begin
				mul_a = work_q;
				mul_b = MAGIC_DIV60;
			end
		endcase
	end

	assign prod = {{EPOCH_W{1'b0}}, mul_a} * {{EPOCH_W{1'b0}}, mul_b};

	always_comb begin
		if (div_q == DV_HR) begin
			quot_d     = {1'b0, prod[2*EPOCH_W-1:33]};
			quot_x_div = (quot_q << 4) + (quot_q << 3);   // times 24
		end else begin
			quot_d     = {5'b00000, prod[2*EPOCH_W-1:37]};
			quot_x_div = (quot_q << 6) - (quot_q << 2);   // times 60
		end
	end

	assign rem = work_q - quot_x_div;

	// ---------------------------------------------------------------
	// leap rule from running residues of the year
	// ---------------------------------------------------------------
	logic       leap;
	logic [8:0] year_len;

	assign leap     = ((mod4_q == 2'd0) && (mod100_q != 7'd0)) || (mod400_q == 9'd0);
	assign year_len = leap ? 9'd366 : 9'd365;
	assign year_done = (days_q < DAYS_W'(year_len));

	logic [4:0] mlen;
	assign mlen       = month_len(leap_q, mon_q);
	assign month_step = (mon_q < LAST_MONTH) && (days_q >= DAYS_W'(mlen));

	assign last_div = (div_q == DV_HR);

	// ---------------------------------------------------------------
	// sequencer
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d         = state_q;
		epoch_in.ready  = 1'b0;
		accept          = 1'b0;
		load_out        = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				epoch_in.ready = 1'b1;
				if (epoch_in.valid) begin
					accept  = 1'b1;
					state_d = ST_DIV;
				end
			end
			ST_DIV: begin
				state_d = ST_REM;
			end
			ST_REM: begin
				state_d = last_div ? ST_YEAR : ST_DIV;
			end
			ST_YEAR: begin
				if (year_done) begin
					state_d = ST_MONTH;
				end
			end
			ST_MONTH: begin
				// hold the finished date until the output register is free
				if (!month_step && (!out_valid_q || cal_out.ready)) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// ---------------------------------------------------------------
	// datapath registers
	// ---------------------------------------------------------------
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					work_q <= clamped;
					div_q  <= DV_SEC;
				end
			end
			ST_DIV: begin
				quot_q <= quot_d;
			end
			ST_REM: begin
				work_q <= quot_q;
				unique case (div_q)
					DV_SEC: begin
						sec_q <= rem[5:0];
						div_q <= DV_MIN;
					end
					DV_MIN: begin
						min_q <= rem[5:0];
						div_q <= DV_HR;
					end
					default: begin
						hr_q     <= rem[4:0];
						days_q   <= quot_q[DAYS_W-1:0];
						year_q   <= BASE_YEAR;
						mod4_q   <= BASE_MOD4;
						mod100_q <= BASE_MOD100;
						mod400_q <= BASE_MOD400;
					end
				endcase
			end
			ST_YEAR: begin
				if (year_done) begin
					leap_q <= leap;
					mon_q  <= '0;
				end else begin
					days_q   <= days_q - DAYS_W'(year_len);
					year_q   <= year_q + 1'b1;
					mod4_q   <= mod4_q + 1'b1;
					mod100_q <= (mod100_q == 7'd99)  ? 7'd0 : mod100_q + 1'b1;
					mod400_q <= (mod400_q == 9'd399) ? 9'd0 : mod400_q + 1'b1;
				end
			end
			ST_MONTH: begin
				if (month_step) begin
					days_q <= days_q - DAYS_W'(mlen);
					mon_q  <= mon_q + 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	// ---------------------------------------------------------------
	// output register
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (cal_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_q.year   <= year_q;
			out_q.month  <= mon_q + 1'b1;
			out_q.day    <= days_q[4:0] + 1'b1;
			out_q.hour   <= hr_q;
			out_q.minute <= min_q;
			out_q.second <= sec_q;
		end
	end

	assign cal_out.valid  = out_valid_q;
	assign cal_out.year   = out_q.year;
	assign cal_out.month  = out_q.month;
	assign cal_out.day    = out_q.day;
	assign cal_out.hour   = out_q.hour;
	assign cal_out.minute = out_q.minute;
	assign cal_out.second = out_q.second;

endmodule

`default_nettype wire

/* sv/estc_check.sv */
// estc_check: port-level checks of the epoch-to-calendar converter, bound to the converter core
// depends on estc_pkg and epoch_seconds_to_calendar_core
`default_nettype none

module estc_check import estc_pkg::*; (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              in_valid,
	input wire logic              in_ready,
	input wire logic              out_valid,
	input wire logic              out_ready,
	input wire logic [YEAR_W-1:0] year,
	input wire logic [3:0]        month,
	input wire logic [4:0]        day,
	input wire logic [4:0]        hour,
	input wire logic [5:0]        minute,
	input wire logic [5:0]        second
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable({year, month, day, hour, minute, second}))
		else $error("stalled result changed");

	// one item in work at a time
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input ready right after a beat");

	// a new result only comes out of a busy period
	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result appeared without work");

	// every shown month, hour, minute and second is in range; year and day are not below their lower bounds
	a_fields_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> month >= 4'd1 && month <= 4'd12 && day >= 5'd1
			&& hour <= 5'd23 && minute <= 6'd59 && second <= 6'd59 && year >= BASE_YEAR)
		else $error("result field out of range");

endmodule

bind epoch_seconds_to_calendar_core estc_check u_estc_check (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (epoch_in.valid),
	.in_ready  (epoch_in.ready),
	.out_valid (cal_out.valid),
	.out_ready (cal_out.ready),
	.year      (cal_out.year),
	.month     (cal_out.month),
	.day       (cal_out.day),
	.hour      (cal_out.hour),
	.minute    (cal_out.minute),
	.second    (cal_out.second)
);

`default_nettype wire

/* dv/estc_calendar_check.sv */
// estc_calendar_check: watches the epoch and calendar channels, predicts the local
// date and time of every accepted epoch beat and compares it with the converter's output
// depends on estc_pkg
`default_nettype none

module estc_calendar_check import estc_pkg::*; (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       epoch_valid,
	input  wire logic                       epoch_ready,
	input  wire logic [EPOCH_W-1:0]         epoch_seconds,
	input  wire logic                       cal_valid,
	input  wire logic                       cal_ready,
	input  wire estc_cal_t                  cal,
	input  wire logic                       cfg_we,
	input  wire logic signed [OFFSET_W-1:0] cfg_wdata,
	output int                              awaiting,
	output int                              mismatches
);

	localparam int REPORT_MAX = 10;
	localparam logic [EPOCH_W-1:0] EPOCH_TOP = '1;

	int unsigned common_month_len [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

	estc_cal_t                     due_dates [$];
	estc_cal_t                     want;
	logic signed [OFFSET_W-1:0]    zone = OFFSET_RESET;
	int                            bad_beats = 0;

	function automatic bit leap_year(input int unsigned y);
		return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
	endfunction

	// local calendar of an epoch count shifted by the zone, clamped to the epoch range
	function automatic estc_cal_t civil_time_of(input logic [EPOCH_W-1:0] epoch,
		input logic signed [OFFSET_W-1:0] zone_s);
		longint          local_s;
		longint unsigned t;
		longint unsigned days;
		int unsigned     yr;
		int unsigned     mon;
		estc_cal_t       c;
		local_s = longint'(epoch) + longint'(zone_s);
		if (local_s < 0)
			t = 0;
		else if (local_s > longint'(EPOCH_TOP))
			t = EPOCH_TOP;
		else
			t = local_s;
		c.second = 6'(t % 60);
		t = t / 60;
		c.minute = 6'(t % 60);
		t = t / 60;
		c.hour = 5'(t % 24);
		days = t / 24;
		yr = BASE_YEAR;
		while (days >= (leap_year(yr) ? 366 : 365)) begin
			days = days - (leap_year(yr) ? 366 : 365);
			yr++;
		end
		mon = 0;
		while (mon < 11 &&
			days >= common_month_len[mon] + ((mon == 1 && leap_year(yr)) ? 1 : 0)) begin
			days = days - common_month_len[mon] - ((mon == 1 && leap_year(yr)) ? 1 : 0);
			mon++;
		end
		c.year  = YEAR_W'(yr);
		c.month = 4'(mon + 1);
		c.day   = 5'(days + 1);
		return c;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zone = OFFSET_RESET;
			due_dates.delete();
			awaiting <= 0;
		end else begin
			if (cfg_we)
				zone = cfg_wdata;
			if (epoch_valid && epoch_ready)
				due_dates.push_back(civil_time_of(epoch_seconds, zone));
			if (cal_valid && cal_ready) begin
				if (due_dates.size() == 0) begin
					bad_beats++;
					if (bad_beats <= REPORT_MAX)
						$display("cal beat with no date pending: got %0d-%0d-%0d %0d:%0d:%0d",
							cal.year, cal.month, cal.day, cal.hour, cal.minute, cal.second);
				end else begin
					want = due_dates.pop_front();
					if (cal.year != want.year || cal.month != want.month ||
						cal.day != want.day || cal.hour != want.hour ||
						cal.minute != want.minute || cal.second != want.second) begin
						bad_beats++;
						if (bad_beats <= REPORT_MAX)
							$display("cal mismatch: expected %0d-%0d-%0d %0d:%0d:%0d, got %0d-%0d-%0d %0d:%0d:%0d",
								want.year, want.month, want.day, want.hour, want.minute,
								want.second, cal.year, cal.month, cal.day, cal.hour,
								cal.minute, cal.second);
					end
				end
			end
			awaiting <= due_dates.size();
		end
		mismatches <= bad_beats;
	end

endmodule

`default_nettype wire

/* dv/tb_top.sv */
// tb_top: stimulus and verdict for epoch_seconds_to_calendar_core
// drives epoch beats and zone offsets, throttles both channels; checking lives in
// estc_calendar_check; depends on estc_pkg and the channel interfaces
`default_nettype none

module tb_top import estc_pkg::*; ();

	localparam int     LIMIT_CYCLES       = 3_000_000;
	localparam int     SEGMENTS           = 8;
	localparam int     RANDOM_PER_SEGMENT = 240;
	localparam int     HOLD_CYCLES        = 900;
	localparam int     SETTLE_CYCLES      = 200;
	localparam longint DAY_S              = 86400;
	localparam longint EPOCH_MAX          = (64'd1 << EPOCH_W) - 1;

	logic                       clk;
	logic                       arst_n;
	logic                       cfg_we;
	logic signed [OFFSET_W-1:0] cfg_wdata;
	logic                       hold_req;

	int     awaiting;
	int     mismatches;
	int     cycles    = 0;
	int     idle_pct  = 0;
	int     stall_pct = 0;
	// zone offset currently loaded, so boundary epochs can be aimed at local time
	longint zone_now  = OFFSET_RESET;

	estc_epoch_if epoch_ch ();
	estc_cal_if   cal_ch ();

	epoch_seconds_to_calendar_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.epoch_in (epoch_ch),
		.cal_out  (cal_ch),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	estc_calendar_check chk (
		.clk          (clk),
		.arst_n       (arst_n),
		.epoch_valid  (epoch_ch.valid),
		.epoch_ready  (epoch_ch.ready),
		.epoch_seconds(epoch_ch.epoch_seconds),
		.cal_valid    (cal_ch.valid),
		.cal_ready    (cal_ch.ready),
		.cal          ({cal_ch.year, cal_ch.month, cal_ch.day, cal_ch.hour,
			cal_ch.minute, cal_ch.second}),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.awaiting     (awaiting),
		.mismatches   (mismatches)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// watchdog: a hung handshake or lost result ends here
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT_CYCLES) begin
			$display("tb: failure");
			$finish;
		end
	end

	// receiver: random stalls at stall_pct, plus one long hold-off so the output
	// register and the sequencer both fill and the input side has to back off
	initial begin : receiver
		int hold_left;
		bit held_once;
		hold_left = 0;
		held_once = 1'b0;
		cal_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req && !held_once) begin
				held_once = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				cal_ch.ready <= 1'b0;
			end else begin
				cal_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
			end
		end
	end

	// seconds from 1970-01-01 to Jan 1 of year y, by counting leap days
	function automatic longint year_start(input int unsigned y);
		int unsigned p;
		p = y - 1;
		return DAY_S * longint'(365 * (y - 1970) + p / 4 - p / 100 + p / 400
			- (1969 / 4 - 1969 / 100 + 1969 / 400));
	endfunction

	// epoch that lands on a given local time under the loaded zone, pinned to range
	function automatic logic [EPOCH_W-1:0] epoch_for_local(input longint local_s);
		longint e;
		e = local_s - zone_now;
		if (e < 0)
			e = 0;
		else if (e > EPOCH_MAX)
			e = EPOCH_MAX;
		return e[EPOCH_W-1:0];
	endfunction

	// random epoch: plain uniform values mixed with counts near both ends of the
	// range and near year, leap-day and midnight boundaries in local time
	function automatic logic [EPOCH_W-1:0] pick_epoch();
		int unsigned y;
		int unsigned kind;
		logic [EPOCH_W-1:0] e;
		kind = $urandom_range(0, 9);
		y = $urandom_range(1970, 2105);
		case (kind)
			3:       e = $urandom_range(0, 200000);
			4:       e = EPOCH_MAX[EPOCH_W-1:0] - $urandom_range(0, 200000);
			5, 6:    e = epoch_for_local(year_start(y + 1) + longint'($urandom_range(0, 6)) - 3);
			7:       e = epoch_for_local(year_start(y) + DAY_S * longint'($urandom_range(58, 60))
				+ longint'($urandom_range(0, 4)) - 2);
			8:       e = epoch_for_local(year_start(y) + DAY_S * longint'($urandom_range(1, 365))
				+ longint'($urandom_range(0, 4)) - 2);
			9:       e = epoch_for_local(year_start(y) + DAY_S * longint'($urandom_range(0, 365))
				+ longint'($urandom_range(0, 86399)));
			default: e = $urandom;
		endcase
		return e;
	endfunction

	// one epoch beat; valid stays up from one beat to the next unless a gap is drawn
	task automatic offer(input logic [EPOCH_W-1:0] e);
		int gap;
		gap = 0;
		// now and then a long gap, so idle time lands on every step of the walk
		if (idle_pct > 0 && $urandom_range(0, 7) == 0)
			gap = $urandom_range(1, 170);
		while (gap > 0) begin
			epoch_ch.valid <= 1'b0;
			@(posedge clk);
			gap--;
		end
		while ($urandom_range(0, 99) < idle_pct) begin
			epoch_ch.valid <= 1'b0;
			@(posedge clk);
		end
		epoch_ch.valid         <= 1'b1;
		epoch_ch.epoch_seconds <= e;
		@(posedge clk);
		while (!epoch_ch.ready)
			@(posedge clk);
	endtask

	// stop offering and wait until every date has come back
	task automatic drain();
		epoch_ch.valid <= 1'b0;
		@(posedge clk);
		while (awaiting != 0)
			@(posedge clk);
	endtask

	// zone writes only with the converter idle
	task automatic write_zone(input logic signed [OFFSET_W-1:0] z);
		drain();
		cfg_we    <= 1'b1;
		cfg_wdata <= z;
		zone_now = z;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin : stimulus
		logic signed [OFFSET_W-1:0] zone_plan [SEGMENTS];
		int seg;
		int z;
		arst_n                 <= 1'b0;
		cfg_we                 <= 1'b0;
		cfg_wdata              <= '0;
		hold_req               <= 1'b0;
		epoch_ch.valid         <= 1'b0;
		epoch_ch.epoch_seconds <= '0;

		// reset value first, then both ends of the stated range, zero, the two
		// extremes of the raw 17-bit pattern, one in-range and one raw random value
		zone_plan[0] = OFFSET_RESET;
		zone_plan[1] = -17'sd43200;
		zone_plan[2] = 17'sd50400;
		zone_plan[3] = 17'sd0;
		zone_plan[4] = -17'sd65536;
		zone_plan[5] = 17'sd65535;
		z = int'($urandom_range(0, 93600)) - 43200;
		zone_plan[6] = z[OFFSET_W-1:0];
		zone_plan[7] = OFFSET_W'($urandom);

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (seg = 0; seg < SEGMENTS; seg++) begin
			// idling mode rotates: none, sender only, receiver only, both
			case (seg % 4)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 53; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 53; end
				default: begin idle_pct = 30; stall_pct = 30; end
			endcase
			if (seg > 0)
				write_zone(zone_plan[seg]);

			if (seg == 0) begin
				// range ends, bit patterns, clamp at the top, leap and year edges
				offer('0);
				offer('1);
				offer(32'hAAAA_AAAA);
				offer(32'h5555_5555);
				offer(32'h8000_0000);
				offer(32'h7FFF_FFFF);
				offer(epoch_for_local(EPOCH_MAX));
				offer(epoch_for_local(EPOCH_MAX + 1));
				offer(epoch_for_local(86399));
				offer(epoch_for_local(year_start(1972) + 59 * DAY_S));
				offer(epoch_for_local(year_start(1973) - 1));
				offer(epoch_for_local(year_start(2000) - 1));
				offer(epoch_for_local(year_start(2000) + 59 * DAY_S + 43200));
				offer(epoch_for_local(year_start(2001) - 1));
				// 2100 is a century year without a leap day
				offer(epoch_for_local(year_start(2100) + 59 * DAY_S - 1));
				offer(epoch_for_local(year_start(2100) + 59 * DAY_S));
				offer(epoch_for_local(year_start(2106)));
			end else if (seg == 1) begin
				// negative zone: sum below zero pins to the epoch start
				offer('0);
				offer(32'd43199);
				offer(32'd43200);
			end

			// long receiver hold-off while the sender keeps offering
			if (seg == 4)
				hold_req <= 1'b1;

			repeat (RANDOM_PER_SEGMENT)
				offer(pick_epoch());
		end

		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0 && awaiting == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

`default_nettype wire
